// ===== rtl/core/bit_column_membership_table_macros.svh =====
// Assertion macros for the bit column membership table.
// Used by the top level only; expects clock and reset in scope.
`ifndef BIT_COLUMN_MEMBERSHIP_TABLE_MACROS_SVH
`define BIT_COLUMN_MEMBERSHIP_TABLE_MACROS_SVH

`define BCMT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define BCMT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bcmt_pkg.sv =====
// Shared types and constants for the bit column membership table.
// No dependencies.
package bcmt_pkg;

   localparam int ROWS_DEF  = 4096;
   localparam int SLOTS_DEF = 64;
   localparam int MAX_LIST  = 64;
   localparam int CMP_W     = 17;

   localparam logic [3:0] OP_ALLOC   = 4'd0;
   localparam logic [3:0] OP_REMOVE  = 4'd1;
   localparam logic [3:0] OP_CLRALL  = 4'd2;
   localparam logic [3:0] OP_SETORG  = 4'd3;
   localparam logic [3:0] OP_QORG    = 4'd4;
   localparam logic [3:0] OP_CLRCOL  = 4'd5;
   localparam logic [3:0] OP_ADD     = 4'd6;
   localparam logic [3:0] OP_COUNT   = 4'd7;
   localparam logic [3:0] OP_LIST    = 4'd8;
   localparam logic [3:0] OP_APPEND  = 4'd9;
   localparam logic [3:0] OP_TRUNC   = 4'd10;
   localparam logic [3:0] OP_EMPTY   = 4'd11;
   localparam logic [3:0] OP_QOCC    = 4'd12;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_NOTOCC = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   localparam logic [1:0] TBL_NONE = 2'd3;

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_CLR,
      MODE_COUNT,
      MODE_LIST,
      MODE_ADD
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_READ  = 5'b00100,
      S_PROC  = 5'b01000,
      S_FINAL = 5'b10000
   } state_type;

   typedef struct packed {
      logic idle;
      logic exec;
      logic read;
      logic proc;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic rd_go;
      logic walk_done;
      logic hold;
      logic out_free;
      logic push;
   } sts_type;

endpackage

// ===== rtl/core/bcmt_if.sv =====
// Request and response channel interfaces.
// No dependencies.
interface bcmt_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [1:0]  table_select;
   logic [5:0]  slot;
   logic [11:0] row;
   logic [11:0] skip_count;
   logic [6:0]  max_count;
   logic [12:0] new_length;
   logic        flag_value;

   modport source (output valid, opcode, table_select, slot, row, skip_count, max_count,
                   new_length, flag_value, input ready);
   modport sink (input valid, opcode, table_select, slot, row, skip_count, max_count,
                 new_length, flag_value, output ready);
endinterface

interface bcmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  slot_id;
   logic        flag;
   logic [12:0] member_total;
   logic [11:0] row_index;
   logic        found;
   logic        last;

   modport source (output valid, status, slot_id, flag, member_total, row_index, found,
                   last, input ready);
   modport sink (input valid, status, slot_id, flag, member_total, row_index, found,
                 last, output ready);
endinterface

// ===== rtl/core/bcmt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bcmt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/bcmt_ctrl.sv =====
// Controller state machine for the bit column membership table.
// Depends on bcmt_pkg.
module bcmt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  bcmt_pkg::sts_type sts,
   output bcmt_pkg::cmd_type cmd
);
   bcmt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcmt_pkg::S_IDLE: begin
            if (req_valid) state_in = bcmt_pkg::S_EXEC;
         end
         bcmt_pkg::S_EXEC: begin
            state_in = bcmt_pkg::S_READ;
         end
         bcmt_pkg::S_READ: begin
            if (sts.rd_go) state_in = bcmt_pkg::S_PROC;
            else if (sts.walk_done) state_in = bcmt_pkg::S_FINAL;
         end
         bcmt_pkg::S_PROC: begin
            if (!sts.hold) state_in = bcmt_pkg::S_READ;
         end
         bcmt_pkg::S_FINAL: begin
            if (sts.out_free) state_in = bcmt_pkg::S_IDLE;
         end
         default: state_in = bcmt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bcmt_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   assign cmd.idle = (state_ff == bcmt_pkg::S_IDLE);
   assign cmd.exec = (state_ff == bcmt_pkg::S_EXEC);
   assign cmd.read = (state_ff == bcmt_pkg::S_READ);
   assign cmd.proc = (state_ff == bcmt_pkg::S_PROC);
   assign cmd.fin  = (state_ff == bcmt_pkg::S_FINAL);
endmodule

// ===== rtl/core/bcmt_datapath.sv =====
// Datapath: slot masks, row counts, row walker, member mask RAM and result register.
// Depends on bcmt_pkg, bcmt_if and bcmt_ram.
module bcmt_datapath #(
   parameter int ROWS  = bcmt_pkg::ROWS_DEF,
   parameter int SLOTS = bcmt_pkg::SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bcmt_pkg::cmd_type cmd,
   output bcmt_pkg::sts_type sts,
   bcmt_req_if.sink          req,
   bcmt_rsp_if.source        rsp
);
   localparam int CW  = $clog2(ROWS + 1);
   localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW  = RIW + 2;
   localparam int XW  = bcmt_pkg::CMP_W;

   logic [3:0]  op_ff;
   logic [1:0]  tsel_ff;
   logic [5:0]  slot_ff;
   logic [11:0] row_ff;
   logic [11:0] skip_ff, skip_in;
   logic [6:0]  maxc_ff;
   logic [12:0] newlen_ff;
   logic        fv_ff;

   logic [63:0] occ_ff, occ_in, orig_ff, orig_in, keep_ff, keep_in;
   logic [CW-1:0] cnt_ff [4];
   logic [CW-1:0] cnt_in [4];
   bcmt_pkg::mode_type mode_ff, mode_in;
   logic [1:0]  wt_ff, wt_in, tl_ff, tl_in;
   logic [CW-1:0] wr_ff, wr_in, n_ff, n_in, pend_row_ff, pend_row_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [6:0]  k_ff, k_in, kmax_ff, kmax_in;
   logic        pend_ff, pend_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [5:0]  res_slot_ff, res_slot_in;
   logic        res_flag_ff, res_flag_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [5:0]  rsp_slot_ff;
   logic        rsp_flag_ff;
   logic [12:0] rsp_total_ff;
   logic [11:0] rsp_row_ff;
   logic        rsp_found_ff, rsp_last_ff;

   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [63:0]   mem_wr_data, mem_rd_data;

   logic [63:0]   free_mask, bmask;
   logic [5:0]    a_idx;
   logic          used, tv, hit, out_free, push_list, push_final, hold;
   logic          rd_go, walk_done;
   logic [1:0]    cidx;
   logic [CW-1:0] cur_cnt;
   logic [XW-1:0] cnt_x, row_x, newlen_x, rows_x, wr_x;

   assign req.ready = cmd.idle;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign used      = ({1'b0, slot_ff} < 7'(SLOTS)) && occ_ff[slot_ff];
   assign bmask     = 64'(1) << slot_ff;
   assign tv        = (tsel_ff != bcmt_pkg::TBL_NONE);
   assign cidx      = cmd.read ? wt_ff : tsel_ff;
   assign cur_cnt   = cnt_ff[cidx];
   assign cnt_x     = XW'(cur_cnt);
   assign row_x     = XW'(row_ff);
   assign newlen_x  = XW'(newlen_ff);
   assign rows_x    = XW'(ROWS);
   assign wr_x      = XW'(wr_ff);
   assign hit       = mem_rd_data[slot_ff];

   always_comb begin
      for (int i = 0; i < 64; i++) begin
         free_mask[i] = (i < SLOTS) && !occ_ff[i];
      end
   end

   always_comb begin
      a_idx = '0;
      for (int i = 63; i >= 0; i--) begin
         if (free_mask[i]) a_idx = 6'(i);
      end
   end

   always_comb begin
      occ_in        = occ_ff;
      orig_in       = orig_ff;
      keep_in       = keep_ff;
      cnt_in        = cnt_ff;
      mode_in       = mode_ff;
      wt_in         = wt_ff;
      tl_in         = tl_ff;
      wr_in         = wr_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_row_in   = pend_row_ff;
      addr_in       = addr_ff;
      k_in          = k_ff;
      kmax_in       = kmax_ff;
      skip_in       = skip_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_flag_in   = res_flag_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_ff;
      push_list     = 1'b0;
      push_final    = 1'b0;
      hold          = 1'b0;
      rd_go         = 1'b0;
      walk_done     = 1'b0;

      if (cmd.idle && req.valid) begin
         skip_in = req.skip_count;
      end

      if (cmd.exec) begin
         mode_in       = bcmt_pkg::MODE_NONE;
         n_in          = '0;
         pend_in       = 1'b0;
         wr_in         = '0;
         k_in          = '0;
         res_status_in = bcmt_pkg::ST_OK;
         res_slot_in   = '0;
         res_flag_in   = 1'b0;
         case (op_ff)
            bcmt_pkg::OP_ALLOC: begin
               if (|free_mask) begin
                  occ_in[a_idx] = 1'b1;
                  res_slot_in   = a_idx;
               end else begin
                  res_status_in = bcmt_pkg::ST_FULL;
               end
            end
            bcmt_pkg::OP_REMOVE: begin
               if (!used) res_status_in = bcmt_pkg::ST_NOTOCC;
               else begin
                  occ_in  = occ_ff & ~bmask;
                  orig_in = orig_ff & ~bmask;
                  mode_in = bcmt_pkg::MODE_CLR;
                  wt_in   = 2'd0;
                  tl_in   = 2'd2;
                  keep_in = ~bmask;
               end
            end
            bcmt_pkg::OP_CLRALL: begin
               occ_in  = '0;
               orig_in = '0;
               mode_in = bcmt_pkg::MODE_CLR;
               wt_in   = 2'd0;
               tl_in   = 2'd2;
               keep_in = '0;
            end
            bcmt_pkg::OP_SETORG: begin
               if (!used) res_status_in = bcmt_pkg::ST_NOTOCC;
               else orig_in[slot_ff] = fv_ff;
            end
            bcmt_pkg::OP_QORG: begin
               res_flag_in = used && orig_ff[slot_ff];
            end
            bcmt_pkg::OP_CLRCOL: begin
               if (!used) res_status_in = bcmt_pkg::ST_NOTOCC;
               else if (tv) begin
                  mode_in = bcmt_pkg::MODE_CLR;
                  wt_in   = tsel_ff;
                  tl_in   = tsel_ff;
                  keep_in = ~bmask;
               end
            end
            bcmt_pkg::OP_ADD: begin
               if (!used) res_status_in = bcmt_pkg::ST_NOTOCC;
               else if (!tv || row_x >= cnt_x) res_status_in = bcmt_pkg::ST_RANGE;
               else mode_in = bcmt_pkg::MODE_ADD;
            end
            bcmt_pkg::OP_COUNT: begin
               if (used && tv) begin
                  mode_in = bcmt_pkg::MODE_COUNT;
                  wt_in   = tsel_ff;
                  tl_in   = tsel_ff;
               end
            end
            bcmt_pkg::OP_LIST: begin
               if (used && tv && maxc_ff != '0) begin
                  mode_in = bcmt_pkg::MODE_LIST;
                  wt_in   = tsel_ff;
                  tl_in   = tsel_ff;
                  kmax_in = (maxc_ff > 7'(bcmt_pkg::MAX_LIST)) ?
                            7'(bcmt_pkg::MAX_LIST) : maxc_ff;
               end
            end
            bcmt_pkg::OP_APPEND: begin
               if (!tv || cnt_x >= rows_x) res_status_in = bcmt_pkg::ST_FULL;
               else begin
                  mem_wr_en        = 1'b1;
                  mem_wr_addr      = {tsel_ff, cur_cnt[RIW-1:0]};
                  mem_wr_data      = '0;
                  cnt_in[tsel_ff]  = cur_cnt + CW'(1);
               end
            end
            bcmt_pkg::OP_TRUNC: begin
               if (tv && newlen_x < cnt_x) cnt_in[tsel_ff] = CW'(newlen_ff);
            end
            bcmt_pkg::OP_EMPTY: begin
               if (tv) cnt_in[tsel_ff] = '0;
            end
            bcmt_pkg::OP_QOCC: begin
               res_flag_in = used;
            end
            default: ;
         endcase
      end

      if (cmd.read) begin
         case (mode_ff)
            bcmt_pkg::MODE_ADD: begin
               rd_go       = 1'b1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = {tsel_ff, row_x[RIW-1:0]};
               addr_in     = mem_rd_addr;
            end
            bcmt_pkg::MODE_CLR, bcmt_pkg::MODE_COUNT, bcmt_pkg::MODE_LIST: begin
               if (wr_x < cnt_x) begin
                  rd_go       = 1'b1;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = {wt_ff, wr_ff[RIW-1:0]};
                  addr_in     = mem_rd_addr;
               end else if (wt_ff != tl_ff) begin
                  wt_in = wt_ff + 2'd1;
                  wr_in = '0;
               end else begin
                  walk_done = 1'b1;
               end
            end
            default: walk_done = 1'b1;
         endcase
      end

      if (cmd.proc) begin
         case (mode_ff)
            bcmt_pkg::MODE_CLR: begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data & keep_ff;
               wr_in       = wr_ff + CW'(1);
            end
            bcmt_pkg::MODE_COUNT: begin
               n_in  = n_ff + CW'(hit);
               wr_in = wr_ff + CW'(1);
            end
            bcmt_pkg::MODE_ADD: begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data | bmask;
               mode_in     = bcmt_pkg::MODE_NONE;
            end
            bcmt_pkg::MODE_LIST: begin
               if (hit && skip_ff != '0) begin
                  skip_in = skip_ff - 12'd1;
                  wr_in   = wr_ff + CW'(1);
               end else if (hit) begin
                  if (pend_ff && !out_free) hold = 1'b1;
                  else begin
                     push_list   = pend_ff;
                     pend_in     = 1'b1;
                     pend_row_in = wr_ff;
                     k_in        = k_ff + 7'd1;
                     wr_in       = wr_ff + CW'(1);
                     if (k_ff + 7'd1 == kmax_ff) mode_in = bcmt_pkg::MODE_NONE;
                  end
               end else begin
                  wr_in = wr_ff + CW'(1);
               end
            end
            default: ;
         endcase
      end

      if (cmd.fin && out_free) push_final = 1'b1;
   end

   assign sts.rd_go     = rd_go;
   assign sts.walk_done = walk_done;
   assign sts.hold      = hold;
   assign sts.out_free  = out_free;
   assign sts.push      = push_list || push_final;

   assign rsp_valid_in = (push_list || push_final) ? 1'b1 :
                         (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         orig_ff      <= '0;
         for (int i = 0; i < 4; i++) cnt_ff[i] <= '0;
         mode_ff      <= bcmt_pkg::MODE_NONE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         orig_ff      <= orig_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idle && req.valid) begin
         op_ff     <= req.opcode;
         tsel_ff   <= req.table_select;
         slot_ff   <= req.slot;
         row_ff    <= req.row;
         maxc_ff   <= req.max_count;
         newlen_ff <= req.new_length;
         fv_ff     <= req.flag_value;
      end
      skip_ff       <= skip_in;
      keep_ff       <= keep_in;
      wt_ff         <= wt_in;
      tl_ff         <= tl_in;
      wr_ff         <= wr_in;
      n_ff          <= n_in;
      pend_row_ff   <= pend_row_in;
      addr_ff       <= addr_in;
      k_ff          <= k_in;
      kmax_ff       <= kmax_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_flag_ff   <= res_flag_in;
      if (push_list) begin
         rsp_status_ff <= bcmt_pkg::ST_OK;
         rsp_slot_ff   <= '0;
         rsp_flag_ff   <= 1'b0;
         rsp_total_ff  <= '0;
         rsp_row_ff    <= 12'(pend_row_ff);
         rsp_found_ff  <= 1'b1;
         rsp_last_ff   <= 1'b0;
      end else if (push_final) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_flag_ff   <= res_flag_ff;
         rsp_total_ff  <= 13'(n_ff);
         rsp_row_ff    <= pend_ff ? 12'(pend_row_ff) : 12'd0;
         rsp_found_ff  <= pend_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.slot_id      = rsp_slot_ff;
   assign rsp.flag         = rsp_flag_ff;
   assign rsp.member_total = rsp_total_ff;
   assign rsp.row_index    = rsp_row_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.last         = rsp_last_ff;

   bcmt_ram #(
      .WIDTH (64),
      .DEPTH (3 * (2 ** RIW))
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );
endmodule

// ===== rtl/core/bit_column_membership_table.sv =====
// Bit column membership table top level: controller, datapath and checks.
// Single-row items pass through the execute, read and final states (add member also visits
// the process state); the next item is taken when the controller is back in idle.
// Count, list, remove, clear column and clear all walk the table rows (read, then process
// each row, table by table); list results wait for a free result register.
// Synchronous reset clears slot masks and row counts; mask RAM contents need no clearing.
`include "bit_column_membership_table_macros.svh"

module bit_column_membership_table #(
   parameter int ROWS  = bcmt_pkg::ROWS_DEF,
   parameter int SLOTS = bcmt_pkg::SLOTS_DEF
) (
   input logic          clock,
   input logic          reset,
   bcmt_req_if.sink     req_ch,
   bcmt_rsp_if.source   rsp_ch
);
   bcmt_pkg::cmd_type cmd;
   bcmt_pkg::sts_type sts;

   bcmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcmt_datapath #(
      .ROWS  (ROWS),
      .SLOTS (SLOTS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   `BCMT_ASSERT_NEXT(a_busy_after_transfer, req_ch.valid && req_ch.ready, !req_ch.ready, "busy")
   `BCMT_ASSERT_NOW(a_push_has_room, sts.push, !rsp_ch.valid || rsp_ch.ready, "overwritten")
   `BCMT_ASSERT_NEXT(a_idle_after_final, cmd.fin && sts.out_free, req_ch.ready, "not idle")
endmodule
